/* rtl/hgp_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP GET parser package
// Shared state encoding, status codes, character constants and result type.
// ----------------------------------------------------------------------------
package hgp_pkg;

    // Path storage limit and derived widths
    localparam int PATH_MAX = 64;
    localparam int CNT_W    = $clog2(PATH_MAX + 1);
    localparam int IDX_W    = $clog2(PATH_MAX);
    localparam int LIM_W    = 7;
    localparam int CMP_W    = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    // Status codes
    localparam logic [2:0] STATUS_PARSING  = 3'd0;
    localparam logic [2:0] STATUS_COMPLETE = 3'd1;
    localparam logic [2:0] STATUS_BAD      = 3'd2;
    localparam logic [2:0] STATUS_NOTFOUND = 3'd3;
    localparam logic [2:0] STATUS_NOMETHOD = 3'd4;

    // Characters of interest
    localparam logic [7:0] CHAR_G  = 8'h47;
    localparam logic [7:0] CHAR_E  = 8'h45;
    localparam logic [7:0] CHAR_T  = 8'h54;
    localparam logic [7:0] CHAR_SP = 8'h20;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Parser states, one-hot
    typedef enum logic [13:0] {
        ST_START   = 14'b00000000000001,
        ST_G       = 14'b00000000000010,
        ST_E       = 14'b00000000000100,
        ST_T       = 14'b00000000001000,
        ST_PATH    = 14'b00000000010000,
        ST_VERSION = 14'b00000000100000,
        ST_HEADER  = 14'b00000001000000,
        ST_CR      = 14'b00000010000000,
        ST_LF      = 14'b00000100000000,
        ST_EOH     = 14'b00001000000000,
        ST_DONE    = 14'b00010000000000,
        ST_BAD     = 14'b00100000000000,
        ST_NOTFND  = 14'b01000000000000,
        ST_NOMETH  = 14'b10000000000000
    } parser_state_t;

    // One result item
    typedef struct packed {
        logic [2:0]       status;
        logic             path_valid;
        logic [7:0]       path_byte;
        logic [IDX_W-1:0] path_index;
        logic [CNT_W-1:0] path_length;
    } result_t;

    // Map a parser state to its reported status
    function automatic logic [2:0] status_of(parser_state_t s);
        logic [2:0] st;
        case (s)
            ST_DONE:   st = STATUS_COMPLETE;
            ST_BAD:    st = STATUS_BAD;
            ST_NOTFND: st = STATUS_NOTFOUND;
            ST_NOMETH: st = STATUS_NOMETHOD;
            default:   st = STATUS_PARSING;
        endcase
        return st;
    endfunction

endpackage

/* rtl/hgp_step.sv */
// ----------------------------------------------------------------------------
// HTTP GET parser step
// Next-state and result logic for one request byte.
// ----------------------------------------------------------------------------
module hgp_step (
    input  hgp_pkg::parser_state_t     state,
    input  logic [hgp_pkg::CNT_W-1:0]  count,
    input  logic [hgp_pkg::LIM_W-1:0]  path_limit,
    input  logic                       restart,
    input  logic [7:0]                 ch,
    output hgp_pkg::parser_state_t     state_next,
    output logic [hgp_pkg::CNT_W-1:0]  count_next,
    output hgp_pkg::result_t           result
);
    import hgp_pkg::*;

    parser_state_t    st_cur;
    logic [CNT_W-1:0] cnt_cur;
    logic [CNT_W-1:0] cnt_inc;
    logic [CMP_W-1:0] lim_eff;
    logic             valid;
    logic [7:0]       pbyte;
    logic [IDX_W-1:0] pidx;

    // Clamp the limit to the path storage size
    assign lim_eff = (CMP_W'(path_limit) > CMP_W'(PATH_MAX)) ? CMP_W'(PATH_MAX)
                                                              : CMP_W'(path_limit);

    // Apply restart before the byte is handled
    assign st_cur  = restart ? ST_START : state;
    assign cnt_cur = restart ? '0 : count;
    assign cnt_inc = cnt_cur + CNT_W'(1);

    // Advance the parser by one byte
    always_comb begin
        state_next = st_cur;
        count_next = cnt_cur;
        valid      = 1'b0;
        pbyte      = '0;
        pidx       = '0;
        case (st_cur)
            ST_START: begin
                count_next = '0;
                state_next = (ch == CHAR_G) ? ST_G : ST_NOMETH;
            end
            ST_G:  state_next = (ch == CHAR_E) ? ST_E : ST_NOMETH;
            ST_E:  state_next = (ch == CHAR_T) ? ST_T : ST_NOMETH;
            ST_T:  state_next = (ch == CHAR_SP) ? ST_PATH : ST_NOMETH;
            ST_PATH: begin
                if (ch == CHAR_SP) begin
                    state_next = ST_VERSION;
                end else begin
                    valid      = 1'b1;
                    pbyte      = ch;
                    pidx       = cnt_cur[IDX_W-1:0];
                    count_next = cnt_inc;
                    if (CMP_W'(cnt_inc) >= lim_eff) begin
                        state_next = ST_NOTFND;
                    end
                end
            end
            ST_VERSION, ST_HEADER: begin
                if (ch == CHAR_CR) begin
                    state_next = ST_CR;
                end
            end
            ST_CR:  state_next = (ch == CHAR_LF) ? ST_LF : ST_BAD;
            ST_LF:  state_next = (ch == CHAR_CR) ? ST_EOH : ST_HEADER;
            ST_EOH: state_next = (ch == CHAR_LF) ? ST_DONE : ST_BAD;
            default: state_next = st_cur;
        endcase
    end

    // Build the result item
    assign result.status      = status_of(state_next);
    assign result.path_valid  = valid;
    assign result.path_byte   = pbyte;
    assign result.path_index  = pidx;
    assign result.path_length = count_next;

endmodule

/* rtl/http_get_request_parser.sv */
// ----------------------------------------------------------------------------
// HTTP GET request parser
// Parses a GET request line one byte per item and reports path and status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one request byte (s_ch) with a restart flag per item;
//   s_restart returns the parser to its start before that byte is handled.
//   Output channel m_*: one result item per input item, carrying the status
//   after the byte and, for path bytes, the byte with its index and the
//   running path length.
//   cfg_we/cfg_wdata write path_limit (reset 64, clamped to 64); write it
//   only while the block is idle.
//   Path: the item waits in the input register and then moves through the
//   parser step into the result register.
//   Throughput: one item per cycle while m_ready is high; the parser state
//   loop closes through the step logic.
//   Reset: aresetn (synchronous, active low) empties both registers, returns
//   the parser to its start and restores the default limit.
//   Stall: while m_ready is low the result holds, the input register fills,
//   and s_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module http_get_request_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [hgp_pkg::LIM_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_restart,
    input  logic [7:0]                  s_ch,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_status,
    output logic                        m_path_valid,
    output logic [7:0]                  m_path_byte,
    output logic [hgp_pkg::IDX_W-1:0]   m_path_index,
    output logic [hgp_pkg::CNT_W-1:0]   m_path_length
);
    import hgp_pkg::*;

    logic             in_valid_reg;
    logic             in_restart_reg;
    logic [7:0]       in_ch_reg;
    logic             out_valid_reg;
    result_t          out_result_reg;
    parser_state_t    state_reg;
    parser_state_t    state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [LIM_W-1:0] limit_reg;
    result_t          step_result;
    logic             out_free;
    logic             advance;

    // Handshake between the two registers
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    hgp_step u_step (
        .state      (state_reg),
        .count      (count_reg),
        .path_limit (limit_reg),
        .restart    (in_restart_reg),
        .ch         (in_ch_reg),
        .state_next (state_next),
        .count_next (count_next),
        .result     (step_result)
    );

    // Hold the path limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIM_W'(PATH_MAX);
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // Capture the input item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_restart_reg <= s_restart;
            in_ch_reg      <= s_ch;
        end
    end

    // Advance the parser state when an item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_START;
            count_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Hold the result item until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_result_reg.status;
    assign m_path_valid  = out_result_reg.path_valid;
    assign m_path_byte   = out_result_reg.path_byte;
    assign m_path_index  = out_result_reg.path_index;
    assign m_path_length = out_result_reg.path_length;

endmodule
